FILE: rtl/ppmfd_pkg.sv
// Shared types, register indexes and helpers for the PPM frame decoder.
// No dependencies; imported by every module of the decoder.
`default_nettype none

package ppmfd_pkg;

   // Configuration register indexes
   localparam int CsrAddrWidth = 2;
   localparam logic [CsrAddrWidth-1:0] CSR_NEGATIVE_PPM      = 2'd0;
   localparam logic [CsrAddrWidth-1:0] CSR_ALT_CHANNEL_ORDER = 2'd1;
   localparam logic [CsrAddrWidth-1:0] CSR_DOUBLE_RATE       = 2'd2;
   localparam logic [CsrAddrWidth-1:0] CSR_NEUTRAL_OFFSET    = 2'd3;

   localparam int CsrDataWidth = 8;
   localparam logic [7:0] NEUTRAL_RESET = 8'd128;

   // Item kinds carried in req_tuser
   localparam logic MODE_EDGE    = 1'b0;
   localparam logic MODE_TIMEOUT = 1'b1;

   localparam int ReqDataWidth = 24;
   localparam int RspDataWidth = 64;
   localparam int NumWidths    = 5;
   localparam int NumHeld      = 7;

   typedef struct packed {
      logic       negative_ppm;
      logic       alt_channel_order;
      logic       double_rate;
      logic [7:0] neutral_offset;
   } cfg_type;

   typedef struct packed {
      logic        mode;
      logic        edge_rising;
      logic [15:0] capture_time;
   } item_type;

   typedef struct packed {
      logic [7:0] throttle;
      logic [7:0] roll;
      logic [7:0] pitch;
      logic [7:0] yaw;
      logic [7:0] aux_five;
      logic [7:0] aux_six;
      logic [7:0] aux_seven;
      logic       frame_ready;
      logic       no_signal;
      logic       long_timeout;
      logic       timer_restart;
   } result_type;

   // Stick channel: subtract neutral mod 256, optional arithmetic halving
   function automatic logic [7:0] stick(input logic [7:0] w, input logic [7:0] neutral,
                                        input logic halve);
      logic [7:0] r;
      r = w - neutral;
      if (halve) begin
         r = {r[7], r[7:1]};
      end
      return r;
   endfunction

   // Halved width must lie in 256..511, i.e. raw bits 15:9 equal one
   function automatic logic width_in_range(input logic [15:0] w);
      return (w[15:9] == 7'd1);
   endfunction

endpackage

`default_nettype wire

FILE: rtl/ppmfd_csr.sv
// Configuration registers of the PPM frame decoder.
// Depends on ppmfd_pkg.
`default_nettype none

module ppmfd_csr (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               csr_we,
   input  wire [ppmfd_pkg::CsrAddrWidth-1:0] csr_addr,
   input  wire [ppmfd_pkg::CsrDataWidth-1:0] csr_wdata,
   output ppmfd_pkg::cfg_type                cfg
);
   import ppmfd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_NEGATIVE_PPM:      cfg_in.negative_ppm      = csr_wdata[0];
            CSR_ALT_CHANNEL_ORDER: cfg_in.alt_channel_order = csr_wdata[0];
            CSR_DOUBLE_RATE:       cfg_in.double_rate       = csr_wdata[0];
            CSR_NEUTRAL_OFFSET:    cfg_in.neutral_offset    = csr_wdata[7:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.negative_ppm      <= 1'b0;
         cfg_ff.alt_channel_order <= 1'b0;
         cfg_ff.double_rate       <= 1'b0;
         cfg_ff.neutral_offset    <= NEUTRAL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: rtl/ppmfd_in_stage.sv
// Request input register of the PPM frame decoder.
// Depends on ppmfd_pkg.
`default_nettype none

module ppmfd_in_stage (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_tvalid,
   output logic                              req_tready,
   input  wire                               req_tuser,
   input  wire [ppmfd_pkg::ReqDataWidth-1:0] req_tdata,
   input  wire                               advance,
   output logic                              item_valid,
   output ppmfd_pkg::item_type               item
);
   import ppmfd_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;
   logic     take;

   // Empty or moving on this cycle: room for the next request
   assign req_tready = !valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload, no reset
   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.mode         <= req_tuser;
         item_ff.edge_rising  <= req_tdata[0];
         item_ff.capture_time <= req_tdata[16:1];
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

FILE: rtl/ppmfd_decode.sv
// Frame decode state and its combinational update for one request.
// Depends on ppmfd_pkg.
`default_nettype none

module ppmfd_decode (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        fire,
   input  wire ppmfd_pkg::item_type   item,
   input  wire ppmfd_pkg::cfg_type    cfg,
   output ppmfd_pkg::result_type      result
);
   import ppmfd_pkg::*;

   logic [2:0]  idx_ff, idx_in;
   logic        second_ff, second_in;
   logic        tout_ff, tout_in;
   logic        long_ff, long_in;
   logic        lost_ff, lost_in;
   logic [7:0]  held_ff [NumHeld];
   logic [7:0]  held_in [NumHeld];
   logic [15:0] ws_ff [NumWidths];
   logic [15:0] ws_in [NumWidths];

   logic        edge_taken;
   logic        lead;
   logic        seq_ok;
   logic        ok;
   logic        frame;
   logic [15:0] t;
   logic [15:0] sub_src;
   logic [15:0] diff;
   logic        range_ok;
   logic [7:0]  h [NumWidths];

   assign t    = item.capture_time;
   assign lead = !second_ff;

   // Edge of the expected polarity
   assign edge_taken = (item.mode == MODE_EDGE) &&
                       (item.edge_rising == (cfg.negative_ppm ^ second_ff));

   // Leading edges belong at even counts, second edges at odd counts
   assign seq_ok = (lead == !idx_ff[0]);

   // One shared subtractor: timestamp minus the stored start of the open width
   always_comb begin
      unique case (idx_ff)
         3'd1:    sub_src = ws_ff[0];
         3'd2:    sub_src = ws_ff[1];
         3'd3:    sub_src = ws_ff[2];
         3'd4:    sub_src = ws_ff[3];
         3'd5:    sub_src = ws_ff[4];
         3'd6:    sub_src = ws_ff[0];
         3'd7:    sub_src = ws_ff[1];
         default: sub_src = ws_ff[0];
      endcase
   end
   assign diff = t - sub_src;

   // Five-width frame check and halved low bytes
   assign range_ok = width_in_range(ws_ff[0]) && width_in_range(ws_ff[1]) &&
                     width_in_range(ws_ff[2]) && width_in_range(ws_ff[3]) &&
                     width_in_range(diff);
   assign h[0] = ws_ff[0][8:1];
   assign h[1] = ws_ff[1][8:1];
   assign h[2] = ws_ff[2][8:1];
   assign h[3] = ws_ff[3][8:1];
   assign h[4] = diff[8:1];

   assign ok    = seq_ok && !((idx_ff == 3'd5) && !range_ok);
   assign frame = edge_taken && seq_ok && (idx_ff == 3'd5) && range_ok;

   // Next state
   always_comb begin
      idx_in    = idx_ff;
      second_in = second_ff;
      tout_in   = tout_ff;
      long_in   = long_ff;
      lost_in   = lost_ff;
      held_in   = held_ff;
      ws_in     = ws_ff;

      if (item.mode == MODE_TIMEOUT) begin
         if (tout_ff) begin
            // Second timeout: signal lost
            long_in   = 1'b0;
            lost_in   = 1'b1;
            idx_in    = 3'd0;
            second_in = 1'b0;
         end else begin
            tout_in = 1'b1;
            long_in = 1'b1;
            idx_in  = 3'd0;
         end
      end else if (edge_taken) begin
         second_in = !second_ff;
         long_in   = 1'b0;
         tout_in   = 1'b0;
         if (seq_ok) begin
            unique case (idx_ff)
               3'd0: ws_in[0] = t;
               3'd1: begin
                  ws_in[1] = t;
                  ws_in[0] = diff;
               end
               3'd2: begin
                  ws_in[2] = t;
                  ws_in[1] = diff;
               end
               3'd3: begin
                  ws_in[3] = t;
                  ws_in[2] = diff;
               end
               3'd4: begin
                  ws_in[4] = t;
                  ws_in[3] = diff;
               end
               3'd5: begin
                  if (range_ok) begin
                     ws_in[0] = t;
                     if (cfg.alt_channel_order) begin
                        held_in[0] = h[2];
                        held_in[1] = stick(h[0], cfg.neutral_offset, cfg.double_rate);
                        held_in[2] = stick(h[1], cfg.neutral_offset, cfg.double_rate);
                     end else begin
                        held_in[0] = h[0];
                        held_in[1] = stick(h[1], cfg.neutral_offset, cfg.double_rate);
                        held_in[2] = stick(h[2], cfg.neutral_offset, cfg.double_rate);
                     end
                     held_in[3] = stick(h[3], cfg.neutral_offset, 1'b0);
                     held_in[4] = h[4];
                     lost_in    = 1'b0;
                  end
               end
               3'd6: begin
                  ws_in[1]   = t;
                  ws_in[0]   = diff;
                  held_in[5] = diff[8:1];
               end
               3'd7: begin
                  ws_in[1]   = diff;
                  held_in[6] = diff[8:1];
               end
               default: ws_in = ws_ff;
            endcase
         end
         if (ok) begin
            idx_in = idx_ff + 3'd1;
         end else begin
            lost_in   = 1'b1;
            idx_in    = 3'd0;
            second_in = 1'b0;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff    <= 3'd0;
         second_ff <= 1'b0;
         tout_ff   <= 1'b0;
         long_ff   <= 1'b0;
         lost_ff   <= 1'b1;
         for (int i = 0; i < NumHeld; i++) begin
            held_ff[i] <= 8'd0;
         end
      end else if (fire) begin
         idx_ff    <= idx_in;
         second_ff <= second_in;
         tout_ff   <= tout_in;
         long_ff   <= long_in;
         lost_ff   <= lost_in;
         held_ff   <= held_in;
      end
   end

   // Timestamp and width store, written before every read
   always_ff @(posedge clock) begin
      if (fire) begin
         ws_ff <= ws_in;
      end
   end

   // Result shows the state after this request
   always_comb begin
      result.throttle      = held_in[0];
      result.roll          = held_in[1];
      result.pitch         = held_in[2];
      result.yaw           = held_in[3];
      result.aux_five      = held_in[4];
      result.aux_six       = held_in[5];
      result.aux_seven     = held_in[6];
      result.frame_ready   = frame;
      result.no_signal     = lost_in;
      result.long_timeout  = long_in;
      result.timer_restart = edge_taken;
   end

endmodule

`default_nettype wire

FILE: rtl/ppmfd_out_stage.sv
// Result output register of the PPM frame decoder.
// Depends on ppmfd_pkg.
`default_nettype none

module ppmfd_out_stage (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               load,
   input  wire ppmfd_pkg::result_type        result,
   output logic                              advance,
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   output logic [ppmfd_pkg::RspDataWidth-1:0] rsp_tdata
);
   import ppmfd_pkg::*;

   logic       valid_ff, valid_in;
   result_type res_ff;

   // Register free or being drained this cycle
   assign advance = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;

   // Pack from the lowest bit up
   assign rsp_tdata = {4'd0,
                       res_ff.timer_restart, res_ff.long_timeout,
                       res_ff.no_signal, res_ff.frame_ready,
                       res_ff.aux_seven, res_ff.aux_six, res_ff.aux_five,
                       res_ff.yaw, res_ff.pitch, res_ff.roll, res_ff.throttle};

endmodule

`default_nettype wire

FILE: rtl/ppm_frame_decoder_top.sv
// Top level of the PPM frame decoder: CSRs, request register, decode, result register.
// Depends on ppmfd_pkg, ppmfd_csr, ppmfd_in_stage, ppmfd_decode, ppmfd_out_stage.
`default_nettype none

// Decodes a pulse-position RC train from edge timestamps and timeout events. Each request
// is either a captured edge (req_tuser = 0) or a timeout expiry (req_tuser = 1) and gives
// exactly one result. The block takes one request per clock unless the result side stalls
// it; an accepted request is held in the request register, then the whole decode (one
// 16-bit subtract, the five range checks and the channel mapping) lands in the result
// register. Backpressure on rsp_tready stalls the request side only once both registers
// hold data. Configuration writes belong in idle periods; the registers reset to positive
// polarity, normal channel order, full rate and a neutral offset of 128.
module ppm_frame_decoder_top (
   input  wire                               clock,
   input  wire                               reset,
   // Request channel
   input  wire                               req_tvalid,
   output logic                              req_tready,
   input  wire                               req_tuser,  // [0] mode
   input  wire [ppmfd_pkg::ReqDataWidth-1:0] req_tdata,  // [0] edge_rising, [16:1] capture_time
   // Result channel
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   // [7:0] throttle, [15:8] roll, [23:16] pitch, [31:24] yaw, [39:32] aux_five,
   // [47:40] aux_six, [55:48] aux_seven, [56] frame_ready, [57] no_signal,
   // [58] long_timeout, [59] timer_restart
   output logic [ppmfd_pkg::RspDataWidth-1:0] rsp_tdata,
   // Configuration port
   input  wire                               csr_we,
   input  wire [ppmfd_pkg::CsrAddrWidth-1:0] csr_addr,
   input  wire [ppmfd_pkg::CsrDataWidth-1:0] csr_wdata
);
   import ppmfd_pkg::*;

   cfg_type    cfg;
   item_type   item;
   result_type result;
   logic       item_valid;
   logic       advance;
   logic       fire;

   assign fire = item_valid && advance;

   ppmfd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ppmfd_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   ppmfd_decode u_decode (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item),
      .cfg    (cfg),
      .result (result)
   );

   ppmfd_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (fire),
      .result     (result),
      .advance    (advance),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

FILE: rtl/ppmfd_checker.sv
// Port-level checks of the PPM frame decoder and their bind to the top level.
// Depends on ppmfd_pkg and ppm_frame_decoder_top.
`default_nettype none

module ppmfd_port_checks (
   input wire                               clock,
   input wire                               reset,
   input wire                               rsp_tvalid,
   input wire                               rsp_tready,
   input wire [ppmfd_pkg::RspDataWidth-1:0] rsp_tdata
);
   // Accepted frame means signal present and timer restarted by that edge
   a_frame_has_signal: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[56]) |-> (!rsp_tdata[57] && rsp_tdata[59]))
      else $error("frame_ready with no_signal set or no timer restart");

   // An edge that restarts the timer always re-arms the short timeout
   a_restart_short: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[59]) |-> !rsp_tdata[58])
      else $error("timer_restart with long timeout armed");

   // Nothing is presented right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // A stalled result holds its payload
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

endmodule

bind ppm_frame_decoder_top ppmfd_port_checks u_ppmfd_port_checks (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

FILE: bench/ppmfd_checker.sv
// Result checker for the PPM frame decoder: watches the request, result and CSR ports,
// predicts each result from the accepted requests and compares field by field.
// Depends on ppmfd_pkg for widths, register indexes and the item/result layouts.

module ppmfd_checker (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_tvalid,
   input  wire                                req_tready,
   input  wire                                req_tuser,   // [0] mode
   input  wire [ppmfd_pkg::ReqDataWidth-1:0]  req_tdata,   // [0] edge_rising, [16:1] capture_time
   input  wire                                rsp_tvalid,
   input  wire                                rsp_tready,
   input  wire [ppmfd_pkg::RspDataWidth-1:0]  rsp_tdata,
   input  wire                                csr_we,
   input  wire [ppmfd_pkg::CsrAddrWidth-1:0]  csr_addr,
   input  wire [ppmfd_pkg::CsrDataWidth-1:0]  csr_wdata,
   output int                                 fail_count,
   output int                                 pending_count
);
   import ppmfd_pkg::*;

   // Mirror of the decoder registers and state
   cfg_type      cfg;
   logic [2:0]   edge_count;
   logic         want_trailing;
   logic         timeout_seen;
   logic         lost_flag;
   logic         long_tmo;
   logic [15:0]  span [NumWidths];
   logic [7:0]   latched [NumHeld];

   result_type   channel_reports [$];
   int           mismatches = 0;

   assign fail_count = mismatches;

   // Stick channel: low byte minus neutral, optionally halved keeping the sign
   function automatic logic [7:0] centered(input logic [15:0] w, input logic halve);
      logic [7:0]        v;
      logic signed [7:0] s;
      v = w[7:0] - cfg.neutral_offset;
      s = v;
      if (halve) begin
         s = s >>> 1;
      end
      return s;
   endfunction

   function automatic void drop_sync();
      lost_flag     = 1'b1;
      edge_count    = 3'd0;
      want_trailing = 1'b0;
   endfunction

   // Advance the mirrored state by one request and return the result it produces
   function automatic result_type decode_request(input item_type it);
      result_type  r;
      logic [15:0] t;
      logic        lead;
      logic        ok;
      logic        in_range;
      r = '0;
      if (it.mode == MODE_TIMEOUT) begin
         if (timeout_seen) begin
            long_tmo = 1'b0;
            drop_sync();
         end else begin
            timeout_seen = 1'b1;
            long_tmo     = 1'b1;
            edge_count   = 3'd0;
         end
      end else if (it.edge_rising == (cfg.negative_ppm ^ want_trailing)) begin
         t               = it.capture_time;
         lead            = !want_trailing;
         ok              = 1'b1;
         want_trailing   = !want_trailing;
         long_tmo        = 1'b0;
         timeout_seen    = 1'b0;
         r.timer_restart = 1'b1;
         if (lead) begin
            case (edge_count)
               3'd0: span[0] = t;
               3'd2: begin
                  span[2] = t;
                  span[1] = t - span[1];
               end
               3'd4: begin
                  span[4] = t;
                  span[3] = t - span[3];
               end
               3'd6: begin
                  span[1]    = t;
                  span[0]    = t - span[0];
                  latched[5] = span[0][8:1];
               end
               default: ok = 1'b0;
            endcase
         end else begin
            case (edge_count)
               3'd1: begin
                  span[1] = t;
                  span[0] = t - span[0];
               end
               3'd3: begin
                  span[3] = t;
                  span[2] = t - span[2];
               end
               3'd5: begin
                  // fifth width closes the main frame: halve all, check 256..511
                  span[4]  = t - span[4];
                  in_range = 1'b1;
                  for (int i = 0; i < NumWidths; i++) begin
                     span[i] = span[i] >> 1;
                     if (span[i][15:8] != 8'd1) begin
                        in_range = 1'b0;
                     end
                  end
                  if (in_range) begin
                     if (cfg.alt_channel_order) begin
                        latched[0] = span[2][7:0];
                        latched[1] = centered(span[0], cfg.double_rate);
                        latched[2] = centered(span[1], cfg.double_rate);
                     end else begin
                        latched[0] = span[0][7:0];
                        latched[1] = centered(span[1], cfg.double_rate);
                        latched[2] = centered(span[2], cfg.double_rate);
                     end
                     latched[3]    = centered(span[3], 1'b0);
                     latched[4]    = span[4][7:0];
                     lost_flag     = 1'b0;
                     span[0]       = t;
                     r.frame_ready = 1'b1;
                  end else begin
                     ok = 1'b0;
                  end
               end
               3'd7: begin
                  span[1]    = t - span[1];
                  latched[6] = span[1][8:1];
               end
               default: ok = 1'b0;
            endcase
         end
         if (ok) begin
            edge_count = edge_count + 3'd1;
         end else begin
            drop_sync();
         end
      end
      r.throttle     = latched[0];
      r.roll         = latched[1];
      r.pitch        = latched[2];
      r.yaw          = latched[3];
      r.aux_five     = latched[4];
      r.aux_six      = latched[5];
      r.aux_seven    = latched[6];
      r.no_signal    = lost_flag;
      r.long_timeout = long_tmo;
      return r;
   endfunction

   task automatic compare_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   // Track CSR writes, check results against the oldest prediction, queue new predictions
   always @(posedge clock) begin
      result_type got;
      result_type want;
      item_type   taken;
      if (reset) begin
         cfg.negative_ppm      = 1'b0;
         cfg.alt_channel_order = 1'b0;
         cfg.double_rate       = 1'b0;
         cfg.neutral_offset    = NEUTRAL_RESET;
         edge_count            = 3'd0;
         want_trailing         = 1'b0;
         timeout_seen          = 1'b0;
         lost_flag             = 1'b1;
         long_tmo              = 1'b0;
         for (int i = 0; i < NumWidths; i++) begin
            span[i] = '0;
         end
         for (int i = 0; i < NumHeld; i++) begin
            latched[i] = '0;
         end
         channel_reports.delete();
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_NEGATIVE_PPM:      cfg.negative_ppm      = csr_wdata[0];
               CSR_ALT_CHANNEL_ORDER: cfg.alt_channel_order = csr_wdata[0];
               CSR_DOUBLE_RATE:       cfg.double_rate       = csr_wdata[0];
               CSR_NEUTRAL_OFFSET:    cfg.neutral_offset    = csr_wdata[7:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got.throttle      = rsp_tdata[7:0];
            got.roll          = rsp_tdata[15:8];
            got.pitch         = rsp_tdata[23:16];
            got.yaw           = rsp_tdata[31:24];
            got.aux_five      = rsp_tdata[39:32];
            got.aux_six       = rsp_tdata[47:40];
            got.aux_seven     = rsp_tdata[55:48];
            got.frame_ready   = rsp_tdata[56];
            got.no_signal     = rsp_tdata[57];
            got.long_timeout  = rsp_tdata[58];
            got.timer_restart = rsp_tdata[59];
            if (channel_reports.size() == 0) begin
               $display("%0t: unexpected result, expected none actual %0h", $time, rsp_tdata);
               mismatches++;
            end else begin
               want = channel_reports.pop_front();
               compare_field("throttle", want.throttle, got.throttle);
               compare_field("roll", want.roll, got.roll);
               compare_field("pitch", want.pitch, got.pitch);
               compare_field("yaw", want.yaw, got.yaw);
               compare_field("aux_five", want.aux_five, got.aux_five);
               compare_field("aux_six", want.aux_six, got.aux_six);
               compare_field("aux_seven", want.aux_seven, got.aux_seven);
               compare_field("frame_ready", want.frame_ready, got.frame_ready);
               compare_field("no_signal", want.no_signal, got.no_signal);
               compare_field("long_timeout", want.long_timeout, got.long_timeout);
               compare_field("timer_restart", want.timer_restart, got.timer_restart);
            end
         end
         if (req_tvalid && req_tready) begin
            taken.mode         = req_tuser;
            taken.edge_rising  = req_tdata[0];
            taken.capture_time = req_tdata[16:1];
            channel_reports.push_back(decode_request(taken));
         end
      end
      pending_count <= channel_reports.size();
   end

endmodule

FILE: bench/tb.sv
// Testbench top for the PPM frame decoder: clock, reset, request and CSR stimulus,
// result-side backpressure and the final verdict.
// Depends on ppmfd_pkg, ppm_frame_decoder_top and the ppmfd_checker module.

module tb;
   import ppmfd_pkg::*;

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic                     req_tuser  = 1'b0;   // [0] mode
   logic [ReqDataWidth-1:0]  req_tdata  = '0;     // [0] edge_rising, [16:1] capture_time
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RspDataWidth-1:0]  rsp_tdata;
   logic                     csr_we     = 1'b0;
   logic [CsrAddrWidth-1:0]  csr_addr   = '0;
   logic [CsrDataWidth-1:0]  csr_wdata  = '0;

   int   fail_count;
   int   pending;

   // Stimulus shaping
   logic cur_neg = 1'b0;
   int   send_idle_pct = 0;
   int   rsp_idle_pct = 0;
   int   seg_items = 0;
   int   hold_seq = 0;
   int   hold_seen = 0;
   int   hold_left = 0;

   // Directed edge spacings, first gap in the low word
   localparam logic [6:0][15:0] CLEAN_GAPS =
      {16'd65535, 16'd1, 16'd700, 16'd1023, 16'd512, 16'd1023, 16'd512};
   localparam logic [6:0][15:0] SHORT_LONG_GAPS =
      {16'd0, 16'd0, 16'd700, 16'd1024, 16'd700, 16'd700, 16'd511};

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   ppm_frame_decoder_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   ppmfd_checker check_i (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tuser     (req_tuser),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_we        (csr_we),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending)
   );

   // Result-side ready: random stalls, plus a long hold-off when one is requested
   always @(posedge clock) begin
      if (hold_seq != hold_seen) begin
         hold_seen  <= hold_seq;
         hold_left  <= 150;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Run limit
   initial begin
      #4800000;
      $display("TB_ERROR");
      $finish;
   end

   task automatic send_item(input logic mode, input logic rising, input logic [15:0] stamp,
                            input bit counted);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {7'd0, stamp, rising};
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      if (counted) begin
         seg_items++;
      end
   endtask

   // Edge of the expected kind; the leading kind is falling unless the train is inverted
   task automatic send_edge(input bit lead, input logic [15:0] stamp);
      send_item(MODE_EDGE, lead ? cur_neg : !cur_neg, stamp, 1'b1);
   endtask

   // Edge of the wrong polarity, which the decoder ignores
   task automatic send_stray(input bit lead, input logic [15:0] stamp);
      send_item(MODE_EDGE, lead ? !cur_neg : cur_neg, stamp, 1'b0);
   endtask

   task automatic send_timeout();
      send_item(MODE_TIMEOUT, 1'($urandom_range(1)), 16'($urandom_range(16'hFFFF)), 1'b1);
   endtask

   // Train of alternating edges starting at the given stamp
   task automatic send_spaced(input logic [15:0] first, input logic [6:0][15:0] gaps,
                              input int n_edges);
      logic [15:0] stamp;
      stamp = first;
      for (int k = 0; k < n_edges; k++) begin
         if (k > 0) begin
            stamp = stamp + gaps[k-1];
         end
         if ($urandom_range(19) == 0) begin
            send_stray(k % 2 == 0, 16'($urandom_range(16'hFFFF)));
         end
         send_edge(k % 2 == 0, stamp);
      end
   endtask

   function automatic logic [15:0] good_gap();
      case ($urandom_range(9))
         0:       return 16'd512;
         1:       return 16'd1023;
         default: return 16'($urandom_range(512, 1023));
      endcase
   endfunction

   function automatic logic [15:0] bad_gap();
      case ($urandom_range(3))
         0:       return 16'd511;
         1:       return 16'd1024;
         2:       return 16'($urandom_range(0, 511));
         default: return 16'($urandom_range(1024, 65535));
      endcase
   endfunction

   // Frame with random content; bad_slot 1..5 puts an out-of-range width there
   task automatic send_frame(input int bad_slot, input int n_edges);
      logic [6:0][15:0] gaps;
      for (int k = 0; k < 7; k++) begin
         if (k + 1 == bad_slot) begin
            gaps[k] = bad_gap();
         end else if (k < 5) begin
            gaps[k] = good_gap();
         end else if ($urandom_range(9) == 0) begin
            gaps[k] = 16'($urandom_range(65535));
         end else begin
            gaps[k] = 16'($urandom_range(1, 4095));
         end
      end
      send_spaced(16'($urandom_range(16'hFFFF)), gaps, n_edges);
   endtask

   // Mostly clean frames; the rest broken frames, cut frames and noise, resynced by timeouts
   task automatic run_segment(input int quota);
      int pick;
      seg_items = 0;
      while (seg_items < quota) begin
         pick = $urandom_range(99);
         if (pick < 65) begin
            send_frame(0, 8);
            if ($urandom_range(1) == 1) begin
               send_timeout();
            end
         end else if (pick < 80) begin
            send_frame($urandom_range(1, 5), 8);
            send_timeout();
            send_timeout();
         end else if (pick < 88) begin
            send_frame(0, $urandom_range(1, 7));
            send_timeout();
            send_timeout();
         end else begin
            repeat ($urandom_range(1, 6)) begin
               if ($urandom_range(3) == 0) begin
                  send_timeout();
               end else begin
                  send_item(MODE_EDGE, 1'($urandom_range(1)), 16'($urandom_range(16'hFFFF)),
                            1'b1);
               end
            end
            send_timeout();
            send_timeout();
         end
      end
      req_tvalid <= 1'b0;
   endtask

   // Wait until every predicted result has come back, then let the pipeline settle
   task automatic drain();
      @(negedge clock);
      while (pending != 0) begin
         @(negedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_cfg(input logic neg, input logic alt, input logic dbl,
                            input logic [7:0] neutral);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_NEGATIVE_PPM;
      csr_wdata <= {7'd0, neg};
      @(posedge clock);
      csr_addr  <= CSR_ALT_CHANNEL_ORDER;
      csr_wdata <= {7'd0, alt};
      @(posedge clock);
      csr_addr  <= CSR_DOUBLE_RATE;
      csr_wdata <= {7'd0, dbl};
      @(posedge clock);
      csr_addr  <= CSR_NEUTRAL_OFFSET;
      csr_wdata <= neutral;
      @(posedge clock);
      csr_we    <= 1'b0;
      cur_neg   = neg;
      @(posedge clock);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 12;
      rsp_idle_pct <= 88;
      @(posedge clock);
      write_cfg(1'b0, 1'b0, 1'b0, NEUTRAL_RESET);

      // Directed: first and second timeout, ignored polarity, clean frame at the range
      // limits with a timer wrap, out-of-range widths on both sides, edge kind out of sequence
      send_timeout();
      send_timeout();
      send_stray(1'b1, 16'hFFFF);
      send_spaced(16'hFFFF, CLEAN_GAPS, 8);
      send_spaced(16'h0000, SHORT_LONG_GAPS, 6);
      send_edge(1'b1, 16'd123);
      send_timeout();
      send_edge(1'b0, 16'hFFFF);
      req_tvalid <= 1'b0;
      drain();

      // Random segments over several settings
      write_cfg(1'b1, 1'b1, 1'b1, 8'd0);
      run_segment(205);
      drain();
      write_cfg(1'b0, 1'b1, 1'b0, 8'd255);
      hold_seq <= hold_seq + 1;
      run_segment(205);
      drain();
      send_idle_pct = 88;
      rsp_idle_pct <= 12;
      write_cfg(1'b1, 1'b0, 1'b1, 8'($urandom_range(255)));
      run_segment(205);
      drain();
      write_cfg(1'b0, 1'b0, 1'b0, NEUTRAL_RESET);
      run_segment(205);
      drain();
      send_idle_pct = 0;
      rsp_idle_pct <= 0;
      write_cfg(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                8'($urandom_range(255)));
      run_segment(205);
      drain();
      write_cfg(1'b1, 1'b1, 1'b0, 8'd255);
      hold_seq <= hold_seq + 1;
      run_segment(205);
      drain();

      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/ppmfd_pkg.sv
rtl/ppmfd_csr.sv
rtl/ppmfd_in_stage.sv
rtl/ppmfd_decode.sv
rtl/ppmfd_out_stage.sv
rtl/ppm_frame_decoder_top.sv
rtl/ppmfd_checker.sv
bench/ppmfd_checker.sv
bench/tb.sv
